/* design/hmf_pkg.sv */
package hmf_pkg;

  localparam int HL     = 8;
  localparam int IDX_W  = (HL > 1) ? $clog2(HL) : 1;
  localparam int VAL_W  = 16;
  localparam int P_W    = 32;
  localparam int S_W    = P_W + IDX_W;
  localparam int Q_W    = S_W + VAL_W;
  localparam int E_W    = Q_W + IDX_W + 1;
  localparam int STP_W  = 3;
  localparam int RES_W  = 17;

  typedef enum logic [1:0] {
    FUNC_HAZARD = 2'd0,
    FUNC_PRIOR  = 2'd1,
    FUNC_OBS    = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CALC,
    ST_DIV,
    ST_OUT,
    ST_DONE,
    ST_CLR
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [5:0]         entry_index;
    logic [VAL_W-1:0]   entry_value;
    logic [VAL_W-1:0]   like_first;
    logic [VAL_W-1:0]   like_second;
  } item_t;

  typedef struct packed {
    logic [RES_W-1:0] first_state_prob;
    logic [RES_W-1:0] hazard_expect;
    logic             degenerate;
  } res_t;

endpackage

/* design/hmf_ram.sv */
module hmf_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int W0    = 16,
  parameter int W1    = 16
) (
  input  logic            clk_i,
  input  logic [AW-1:0]   rd_addr_i,
  output logic [W1+W0-1:0] rd_data_o,
  input  logic [AW-1:0]   wr_addr_i,
  input  logic            we0_i,
  input  logic            we1_i,
  input  logic [W0-1:0]   wd0_i,
  input  logic [W1-1:0]   wd1_i
);

  logic [W0-1:0] lane0_mem [DEPTH];
  logic [W1-1:0] lane1_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we0_i) begin
      lane0_mem[wr_addr_i] <= wd0_i;
    end
    if (we1_i) begin
      lane1_mem[wr_addr_i] <= wd1_i;
    end
    rd_data_o <= {lane1_mem[rd_addr_i], lane0_mem[rd_addr_i]};
  end

endmodule

/* design/hmf_div.sv */
module hmf_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [hmf_pkg::Q_W-1:0] num_i,
  input  logic [hmf_pkg::E_W-1:0] den_i,
  output logic                    done_o,
  output logic [hmf_pkg::P_W-1:0] quo_o
);
  import hmf_pkg::*;

  localparam int CNT_W = $clog2(P_W);

  logic [E_W-1:0]   rem_q;
  logic [P_W-2:0]   quo_q;
  logic             sat_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [E_W:0]     rem_sh;
  logic [E_W:0]     rem_nx;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_i};
  assign rem_nx = ge ? (rem_sh - {1'b0, den_i}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(P_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= E_W'(num_i);
      quo_q <= '0;
      sat_q <= E_W'(num_i) >= den_i;
    end else if (busy_q) begin
      rem_q <= rem_nx[E_W-1:0];
      quo_q <= {quo_q[P_W-3:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? {1'b1, {(P_W-1){1'b0}}} : {1'b0, quo_q};

endmodule

/* design/hmf_core.sv */
module hmf_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hmf_pkg::item_t item_i,
  input  logic [15:0]    mix_rate_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output hmf_pkg::res_t  res_o
);
  import hmf_pkg::*;

  localparam int MA_W = P_W + 17;
  localparam int MB_W = S_W + 17;
  localparam int T_W  = S_W + 16;
  localparam int PR_W = P_W + 17;
  localparam int QA_W = P_W + IDX_W;
  localparam int HA_W = PR_W + IDX_W;
  localparam int SC_W = 2 * Q_W;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] lvl_q, lvl_d;
  logic [STP_W-1:0] stp_q, stp_d;
  logic             lvl_last;

  logic [31:0]       tab_rd;
  logic [SC_W+63:0]  st_rd;
  logic [15:0]       hz, pw;
  logic [P_W-1:0]    p1, p2;
  logic [Q_W-1:0]    sq1, sq2;

  logic             tab_we_h, tab_we_p, st_we_post, st_we_scr;
  logic [IDX_W-1:0] wr_addr;
  logic [15:0]      tab_wd;
  logic [63:0]      post_wd;
  logic             div_start;
  logic             div_done1, div_done2;
  logic [P_W-1:0]   quo1, quo2;
  logic             idx_ok;
  logic [P_W-1:0]   v14;

  logic [16:0] nk, nh;
  logic [15:0] l1_q, l2_q, w_q;
  logic [S_W-1:0] s1_q, s2_q;
  logic [MA_W-1:0] m1_q, m2_q, m3_q, m4_q, u1_q, u2_q;
  logic [MB_W-1:0] m5_q, m6_q, m7_q, m8_q;
  logic [P_W-1:0] a1_q, a2_q;
  logic [S_W-1:0] b1_q, b2_q, r1_q, r2_q;
  logic [T_W-1:0] t1_q, t2_q, v1_q, v2_q;
  logic [Q_W-1:0] q1_q, q2_q;
  logic [E_W-1:0] e_q, e_sum;
  logic           degen_q;
  logic [PR_W-1:0] prod_q;
  logic [QA_W-1:0] qacc_q;
  logic [HA_W-1:0] hacc_q;
  logic [QA_W-16:0] qsh;
  logic [HA_W-32:0] hsh;

  assign hz  = tab_rd[15:0];
  assign pw  = tab_rd[31:16];
  assign p1  = st_rd[P_W-1:0];
  assign p2  = st_rd[2*P_W-1:P_W];
  assign sq1 = st_rd[64 +: Q_W];
  assign sq2 = st_rd[64+Q_W +: Q_W];

  assign nk = 17'h10000 - {1'b0, mix_rate_i};
  assign nh = 17'h10000 - {1'b0, hz};
  assign lvl_last = (lvl_q == IDX_W'(HL - 1));
  assign e_sum = e_q + E_W'(q1_q) + E_W'(q2_q);
  assign idx_ok = {1'b0, item_i.entry_index} < 7'(HL);
  assign v14 = {2'b00, item_i.entry_value, 14'b0};

  hmf_ram #(.DEPTH(HL), .AW(IDX_W), .W0(16), .W1(16)) u_tab (
    .clk_i     (clk_i),
    .rd_addr_i (lvl_q),
    .rd_data_o (tab_rd),
    .wr_addr_i (wr_addr),
    .we0_i     (tab_we_h),
    .we1_i     (tab_we_p),
    .wd0_i     (tab_wd),
    .wd1_i     (tab_wd)
  );

  // lane 0 holds the posterior pair, lane 1 the unnormalized pair of this step
  hmf_ram #(.DEPTH(HL), .AW(IDX_W), .W0(64), .W1(SC_W)) u_state (
    .clk_i     (clk_i),
    .rd_addr_i (lvl_q),
    .rd_data_o (st_rd),
    .wr_addr_i (wr_addr),
    .we0_i     (st_we_post),
    .we1_i     (st_we_scr),
    .wd0_i     (post_wd),
    .wd1_i     ({q2_q, q1_q})
  );

  hmf_div u_div1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (sq1), .den_i (e_q), .done_o (div_done1), .quo_o (quo1)
  );

  hmf_div u_div2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (sq2), .den_i (e_q), .done_o (div_done2), .quo_o (quo2)
  );

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    stp_d   = stp_q;
    case (state_q)
      ST_CLR: begin
        if (lvl_last) begin
          lvl_d   = '0;
          state_d = ST_IDLE;
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && item_i.func == FUNC_OBS) begin
          state_d = ST_SUM;
          lvl_d   = '0;
          stp_d   = '0;
        end
      end
      ST_SUM: begin
        if (stp_q == STP_W'(0)) begin
          stp_d = STP_W'(1);
        end else begin
          stp_d = '0;
          if (lvl_last) begin
            lvl_d   = '0;
            state_d = ST_CALC;
          end else begin
            lvl_d = lvl_q + 1'b1;
          end
        end
      end
      ST_CALC: begin
        if (stp_q == STP_W'(7)) begin
          stp_d = '0;
          if (lvl_last) begin
            lvl_d   = '0;
            state_d = (e_sum == '0) ? ST_OUT : ST_DIV;
          end else begin
            lvl_d = lvl_q + 1'b1;
          end
        end else begin
          stp_d = stp_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (stp_q != STP_W'(2)) begin
          stp_d = stp_q + 1'b1;
        end else if (div_done1 && div_done2) begin
          stp_d = '0;
          if (lvl_last) begin
            lvl_d   = '0;
            state_d = ST_OUT;
          end else begin
            lvl_d = lvl_q + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (stp_q != STP_W'(2)) begin
          stp_d = stp_q + 1'b1;
        end else begin
          stp_d = '0;
          if (lvl_last) begin
            state_d = ST_DONE;
          end else begin
            lvl_d = lvl_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    tab_we_h    = 1'b0;
    tab_we_p    = 1'b0;
    st_we_post  = 1'b0;
    st_we_scr   = 1'b0;
    wr_addr     = lvl_q;
    tab_wd      = item_i.entry_value;
    post_wd     = {quo2, quo1};
    div_start   = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      // zero one level of the tables and posteriors per cycle
      ST_CLR: begin
        tab_we_h   = 1'b1;
        tab_we_p   = 1'b1;
        st_we_post = 1'b1;
        tab_wd     = '0;
        post_wd    = '0;
      end
      ST_IDLE: begin
        wr_addr = item_i.entry_index[IDX_W-1:0];
        post_wd = {v14, v14};
        if (in_valid_i && idx_ok) begin
          tab_we_h   = (item_i.func == FUNC_HAZARD);
          tab_we_p   = (item_i.func == FUNC_PRIOR);
          st_we_post = (item_i.func == FUNC_PRIOR);
        end
      end
      ST_CALC: st_we_scr = (stp_q == STP_W'(7));
      ST_DIV: begin
        div_start  = (stp_q == STP_W'(1));
        st_we_post = (stp_q == STP_W'(2)) && div_done1 && div_done2;
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      lvl_q   <= '0;
      stp_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      stp_q   <= stp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        s1_q    <= '0;
        s2_q    <= '0;
        e_q     <= '0;
        qacc_q  <= '0;
        hacc_q  <= '0;
        degen_q <= 1'b0;
        l1_q    <= item_i.like_first;
        l2_q    <= item_i.like_second;
      end
      ST_SUM: begin
        if (stp_q == STP_W'(1)) begin
          s1_q <= s1_q + S_W'(p1);
          s2_q <= s2_q + S_W'(p2);
        end
      end
      ST_CALC: begin
        case (stp_q)
          STP_W'(1): begin
            w_q  <= pw;
            m1_q <= MA_W'(p1) * MA_W'(nh);
            m2_q <= MA_W'(p2) * MA_W'(hz);
            m3_q <= MA_W'(p1) * MA_W'(hz);
            m4_q <= MA_W'(p2) * MA_W'(nh);
            m5_q <= MB_W'(s1_q) * MB_W'(nh);
            m6_q <= MB_W'(s2_q) * MB_W'(hz);
            m7_q <= MB_W'(s1_q) * MB_W'(hz);
            m8_q <= MB_W'(s2_q) * MB_W'(nh);
          end
          STP_W'(2): begin
            a1_q <= P_W'((m1_q + m2_q) >> 16);
            a2_q <= P_W'((m3_q + m4_q) >> 16);
            b1_q <= S_W'((m5_q + m6_q) >> 16);
            b2_q <= S_W'((m7_q + m8_q) >> 16);
          end
          STP_W'(3): begin
            t1_q <= T_W'(b1_q) * T_W'(w_q);
            t2_q <= T_W'(b2_q) * T_W'(w_q);
            u1_q <= MA_W'(a1_q) * MA_W'(nk);
            u2_q <= MA_W'(a2_q) * MA_W'(nk);
          end
          STP_W'(4): begin
            v1_q <= T_W'(t1_q >> 16) * T_W'(mix_rate_i);
            v2_q <= T_W'(t2_q >> 16) * T_W'(mix_rate_i);
          end
          STP_W'(5): begin
            r1_q <= S_W'(((T_W+1)'(u1_q) + (T_W+1)'(v1_q)) >> 16);
            r2_q <= S_W'(((T_W+1)'(u2_q) + (T_W+1)'(v2_q)) >> 16);
          end
          STP_W'(6): begin
            q1_q <= Q_W'(r1_q) * Q_W'(l1_q);
            q2_q <= Q_W'(r2_q) * Q_W'(l2_q);
          end
          STP_W'(7): begin
            e_q <= e_sum;
            if (lvl_last) begin
              degen_q <= (e_sum == '0);
            end
          end
          default: ;
        endcase
      end
      ST_OUT: begin
        if (stp_q == STP_W'(1)) begin
          prod_q <= PR_W'(hz) * PR_W'({1'b0, p1} + {1'b0, p2});
          qacc_q <= qacc_q + QA_W'(p1);
        end else if (stp_q == STP_W'(2)) begin
          hacc_q <= hacc_q + HA_W'(prod_q);
        end
      end
      default: ;
    endcase
  end

  // q1.31 probability sum and q5.47 hazard sum scaled down to q1.16, saturated at one
  assign qsh = qacc_q[QA_W-1:15];
  assign hsh = hacc_q[HA_W-1:31];

  always_comb begin
    res_o.first_state_prob = (qsh > (QA_W-15)'(65536)) ? 17'h10000 : qsh[16:0];
    res_o.hazard_expect    = (hsh > (HA_W-31)'(65536)) ? 17'h10000 : hsh[16:0];
    res_o.degenerate       = degen_q;
  end

endmodule

/* design/hazard_mixture_hmm_filter_top.sv */
// an observation runs through the sum, calculate, divide and output passes over all
// HL hazard levels before its result word is registered; the divide pass is skipped
// when the normalizer is zero
// throughput: one observation at a time; the two bit-serial dividers work per level
// in order: read, start, 31 quotient bits, write back
// reset: asynchronous; then the tables and posteriors are zeroed level by level, input held off
module hazard_mixture_hmm_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // entry_index, entry_value, like_first, like_second
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // first_state_prob, hazard_expect
  output logic [0:0]  m_axis_tuser,  // degenerate
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import hmf_pkg::*;

  logic [15:0] mix_rate_q;
  item_t       item;
  logic        core_ready;
  logic        res_valid, res_ready;
  res_t        res;
  logic        out_valid_q;
  res_t        out_res_q;

  assign item.func        = func_e'(s_axis_tuser);
  assign item.entry_index = s_axis_tdata[5:0];
  assign item.entry_value = s_axis_tdata[21:6];
  assign item.like_first  = s_axis_tdata[37:22];
  assign item.like_second = s_axis_tdata[53:38];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_rate_q <= '0;
    end else if (cfg_valid_i) begin
      mix_rate_q <= cfg_data_i;
    end
  end

  hmf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (core_ready),
    .item_i      (item),
    .mix_rate_i  (mix_rate_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign s_axis_tready = core_ready;

  // output word register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_res_q.hazard_expect, out_res_q.first_state_prob};
  assign m_axis_tuser  = out_res_q.degenerate;

  a_obs_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_OBS) |=> !s_axis_tready)
    else $error("input still open after observation word");

  a_out_from_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_valid && res_ready))
    else $error("output word without core result");

  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("result pending while input open");

endmodule
